[rtl/plfm_pkg.sv]
// Shared types and constants for the price level FIFO matcher.
package plfm_pkg;

  // Queue geometry
  localparam int unsigned Depth      = 16;
  localparam int unsigned CntW       = $clog2(Depth + 1);
  localparam int unsigned MaxResults = 16;
  localparam int unsigned TradeCntW  = $clog2(MaxResults);

  // Field widths
  localparam int unsigned IdW  = 32;
  localparam int unsigned QtyW = 32;

  // Command codes
  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_MATCH  = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_e;

  // Result status codes
  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_NOT_FOUND = 2'd2,
    STAT_NO_TRADE  = 2'd3
  } status_e;

  // Per-cell control from the sequencer
  typedef struct packed {
    logic shift_all;  // take neighbor's entry (head removal)
    logic del_en;     // delete in progress: shift if at or past first hit
    logic dec_en;     // subtract fill from own quantity (head cell)
    logic load_new;   // write the inserted order (tail cell)
  } cell_ctrl_t;

endpackage

[rtl/plfm_cell.sv]
// One queue slot: holds an order, searches by id and shifts toward the head.
module plfm_cell (
  input  logic                         clk_i,
  input  plfm_pkg::cell_ctrl_t         ctrl_i,
  input  logic                         in_range_i,
  input  logic [plfm_pkg::IdW-1:0]     key_i,
  input  logic [plfm_pkg::IdW-1:0]     new_id_i,
  input  logic [plfm_pkg::QtyW-1:0]    new_qty_i,
  input  logic [plfm_pkg::QtyW-1:0]    dec_qty_i,
  input  logic [plfm_pkg::IdW-1:0]     nb_id_i,
  input  logic [plfm_pkg::QtyW-1:0]    nb_qty_i,
  input  logic                         hit_seen_i,
  output logic                         hit_seen_o,
  output logic [plfm_pkg::IdW-1:0]     id_o,
  output logic [plfm_pkg::QtyW-1:0]    qty_o
);

  logic [plfm_pkg::IdW-1:0]  id_q, id_d;
  logic [plfm_pkg::QtyW-1:0] qty_q, qty_d;
  logic                      hit;
  logic                      take;

  // Search chain: a hit here or anywhere closer to the head
  assign hit        = in_range_i && (id_q == key_i);
  assign hit_seen_o = hit_seen_i | hit;

  assign take = ctrl_i.shift_all | (ctrl_i.del_en & hit_seen_o);

  // Slot update: shift wins over decrement and load
  always_comb begin
    id_d  = id_q;
    qty_d = qty_q;
    if (take) begin
      id_d  = nb_id_i;
      qty_d = nb_qty_i;
    end else if (ctrl_i.dec_en) begin
      qty_d = qty_q - dec_qty_i;
    end else if (ctrl_i.load_new) begin
      id_d  = new_id_i;
      qty_d = new_qty_i;
    end
  end

  // Payload only, no reset
  always_ff @(posedge clk_i) begin
    id_q  <= id_d;
    qty_q <= qty_d;
  end

  assign id_o  = id_q;
  assign qty_o = qty_q;

endmodule

[rtl/price_level_fifo_matcher_core.sv]
// Top level: one price level queue built from a chain of order cells.
//
// Usage: commands enter on the in_valid_i/in_ready_o channel (cmd_i, order_id_i,
// quantity_i) and results leave on out_valid_o/out_ready_i, one transaction per
// result. Insert, delete, nop and no-trade matches give one result; a match
// that trades gives one result per fill, up to 16, with last_o on the final one.
// The level price is written through cfg_valid_i/cfg_data_i, always ready.
// Timing: insert, delete and no-trade results are valid the cycle after the
// command is accepted; a trading match first enters its match state and then
// gives its fills. Insert and delete can be accepted back to back when results
// are drained; a match gives one fill per cycle while they are drained, set by
// the single head cell compare and subtract. One command is in work at a time.
// Reset empties the queue and clears the level price; no clearing pass runs.
// When the receiver stalls, the output register holds its result and no new
// command or fill proceeds until it is taken.
module price_level_fifo_matcher_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [31:0]                    cfg_data_i,
  // command channel
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [1:0]                     cmd_i,
  input  logic [plfm_pkg::IdW-1:0]       order_id_i,
  input  logic [plfm_pkg::QtyW-1:0]      quantity_i,
  // result channel
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [1:0]                     status_o,
  output logic [plfm_pkg::IdW-1:0]       resting_id_o,
  output logic [plfm_pkg::IdW-1:0]       incoming_id_o,
  output logic [plfm_pkg::QtyW-1:0]      fill_qty_o,
  output logic [31:0]                    trade_price_o,
  output logic [plfm_pkg::QtyW-1:0]      incoming_left_o,
  output logic [plfm_pkg::CntW-1:0]      orders_waiting_o,
  output logic                           last_o
);

  typedef enum logic {
    S_IDLE,
    S_MATCH
  } state_e;

  state_e                          state_q, state_d;
  logic [plfm_pkg::CntW-1:0]       count_q, count_d;
  logic [31:0]                     price_q;
  logic [plfm_pkg::IdW-1:0]        inc_id_q, inc_id_d;
  logic [plfm_pkg::QtyW-1:0]       left_q, left_d;
  logic [plfm_pkg::TradeCntW-1:0]  ntr_q, ntr_d;

  // output register
  logic                            out_valid_q, out_load;
  plfm_pkg::status_e               status_q, status_d;
  logic [plfm_pkg::IdW-1:0]        rid_q, rid_d, iid_q, iid_d;
  logic [plfm_pkg::QtyW-1:0]       fill_q, fill_d, oleft_q, oleft_d;
  logic [31:0]                     tprice_q, tprice_d;
  logic [plfm_pkg::CntW-1:0]       owait_q, owait_d;
  logic                            last_q, last_d;

  // cell chain
  plfm_pkg::cell_ctrl_t            ctrl   [plfm_pkg::Depth];
  logic [plfm_pkg::IdW-1:0]        c_id   [plfm_pkg::Depth+1];
  logic [plfm_pkg::QtyW-1:0]       c_qty  [plfm_pkg::Depth+1];
  logic                            hit_ch [plfm_pkg::Depth+1];
  logic [plfm_pkg::Depth-1:0]      in_range;
  logic [plfm_pkg::Depth-1:0]      at_tail;

  logic                            out_free, in_fire;
  logic                            ins_en, del_en, step_en, head_rm;
  logic                            found, full;
  logic [plfm_pkg::QtyW-1:0]       fill, left_n, head_n;
  logic [plfm_pkg::CntW-1:0]       cnt_after;
  plfm_pkg::cmd_e                  cmd;

  assign cfg_ready_o = 1'b1;
  assign cmd         = plfm_pkg::cmd_e'(cmd_i);
  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE) && out_free;
  assign in_fire     = in_valid_i && in_ready_o;
  assign full        = (count_q >= plfm_pkg::CntW'(plfm_pkg::Depth));
  assign found       = hit_ch[plfm_pkg::Depth];

  assign ins_en  = in_fire && (cmd == plfm_pkg::CMD_INSERT) && !full;
  assign del_en  = in_fire && (cmd == plfm_pkg::CMD_DELETE);
  assign step_en = (state_q == S_MATCH) && out_free;

  // Head fill arithmetic
  assign fill    = (left_q < c_qty[0]) ? left_q : c_qty[0];
  assign left_n  = left_q - fill;
  assign head_n  = c_qty[0] - fill;
  assign head_rm = step_en && (head_n == '0);
  assign cnt_after = count_q - plfm_pkg::CntW'(head_rm);

  // Per-cell control and chain wiring
  assign hit_ch[0]                = 1'b0;
  assign c_id[plfm_pkg::Depth]    = '0;
  assign c_qty[plfm_pkg::Depth]   = '0;

  for (genvar g = 0; g < plfm_pkg::Depth; g++) begin : g_cell
    assign in_range[g] = (count_q > plfm_pkg::CntW'(g));
    assign at_tail[g]  = (count_q == plfm_pkg::CntW'(g));

    always_comb begin
      ctrl[g].shift_all = head_rm;
      ctrl[g].del_en    = del_en;
      ctrl[g].dec_en    = (g == 0) ? step_en : 1'b0;
      ctrl[g].load_new  = ins_en && at_tail[g];
    end

    plfm_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl[g]),
      .in_range_i (in_range[g]),
      .key_i      (order_id_i),
      .new_id_i   (order_id_i),
      .new_qty_i  (quantity_i),
      .dec_qty_i  (fill),
      .nb_id_i    (c_id[g+1]),
      .nb_qty_i   (c_qty[g+1]),
      .hit_seen_i (hit_ch[g]),
      .hit_seen_o (hit_ch[g+1]),
      .id_o       (c_id[g]),
      .qty_o      (c_qty[g])
    );
  end

  // Sequencer and result formation
  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    inc_id_d = inc_id_q;
    left_d   = left_q;
    ntr_d    = ntr_q;
    out_load = 1'b0;
    status_d = plfm_pkg::STAT_OK;
    rid_d    = '0;
    iid_d    = '0;
    fill_d   = '0;
    tprice_d = '0;
    oleft_d  = '0;
    owait_d  = count_q;
    last_d   = 1'b1;

    if (in_fire) begin
      case (cmd)
        plfm_pkg::CMD_INSERT: begin
          out_load = 1'b1;
          if (full) begin
            status_d = plfm_pkg::STAT_FULL;
          end else begin
            count_d = count_q + plfm_pkg::CntW'(1);
            owait_d = count_d;
          end
        end
        plfm_pkg::CMD_DELETE: begin
          out_load = 1'b1;
          if (found) begin
            count_d = count_q - plfm_pkg::CntW'(1);
            owait_d = count_d;
          end else begin
            status_d = plfm_pkg::STAT_NOT_FOUND;
          end
        end
        plfm_pkg::CMD_MATCH: begin
          if (quantity_i == '0 || count_q == '0) begin
            out_load = 1'b1;
            status_d = plfm_pkg::STAT_NO_TRADE;
            iid_d    = order_id_i;
            oleft_d  = quantity_i;
          end else begin
            state_d  = S_MATCH;
            inc_id_d = order_id_i;
            left_d   = quantity_i;
            ntr_d    = '0;
          end
        end
        default: begin
          out_load = 1'b1;
        end
      endcase
    end else if (step_en) begin
      // One fill against the head order
      out_load = 1'b1;
      count_d  = cnt_after;
      left_d   = left_n;
      ntr_d    = ntr_q + plfm_pkg::TradeCntW'(1);
      rid_d    = c_id[0];
      iid_d    = inc_id_q;
      fill_d   = fill;
      tprice_d = price_q;
      oleft_d  = left_n;
      owait_d  = cnt_after;
      last_d   = (left_n == '0) || (cnt_after == '0) ||
                 (ntr_q == plfm_pkg::TradeCntW'(plfm_pkg::MaxResults - 1));
      if (last_d) begin
        state_d = S_IDLE;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      price_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (cfg_valid_i && cfg_ready_o) begin
        price_q <= cfg_data_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    inc_id_q <= inc_id_d;
    left_q   <= left_d;
    ntr_q    <= ntr_d;
    if (out_load) begin
      status_q <= status_d;
      rid_q    <= rid_d;
      iid_q    <= iid_d;
      fill_q   <= fill_d;
      tprice_q <= tprice_d;
      oleft_q  <= oleft_d;
      owait_q  <= owait_d;
      last_q   <= last_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign resting_id_o     = rid_q;
  assign incoming_id_o    = iid_q;
  assign fill_qty_o       = fill_q;
  assign trade_price_o    = tprice_q;
  assign incoming_left_o  = oleft_q;
  assign orders_waiting_o = owait_q;
  assign last_o           = last_q;

`ifndef NO_ASSERTIONS
  // Queue never holds more orders than cells
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= plfm_pkg::CntW'(plfm_pkg::Depth))
    else $error("order count exceeds queue depth");

  // While matching, the incoming order still has quantity and the queue is not empty
  a_match_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_MATCH |-> (left_q != '0) && (count_q != '0))
    else $error("match running with nothing to fill");

  // Error and no-trade results always close their command
  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != plfm_pkg::STAT_OK) |-> last_o)
    else $error("non-trade result without last flag");
`endif

endmodule
